// ===== hw/rtl/dchk_pkg.sv =====
// Package for the HTTP body dechunker: widths, phase encoding, register indexes,
// the decoder state and result structs, and the hex digit classifier.
// It has no dependencies. The step logic and the top level both import it.
`default_nettype none

package dchk_pkg;

	// Width of the chunk size accumulator.
	localparam int SIZE_BITS = 32;
	// Width of the fixed content length register.
	localparam int LEN_BITS = 32;
	// The byte counter serves both modes, so it is as wide as the wider of the two.
	localparam int CNT_BITS = (SIZE_BITS > LEN_BITS) ? SIZE_BITS : LEN_BITS;

	localparam int BYTE_BITS = 8;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = LEN_BITS;
	localparam int OUT_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_CHUNKED_MODE = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CONTENT_LENGTH = 1'b1;

	localparam logic [BYTE_BITS-1:0] CHAR_CR = 8'h0d;
	localparam logic [BYTE_BITS-1:0] CHAR_LF = 8'h0a;
	localparam logic [BYTE_BITS-1:0] CHAR_SP = 8'h20;
	localparam logic [BYTE_BITS-1:0] CHAR_TAB = 8'h09;

	// Decoder phases. The first four cover the chunk size line.
	typedef enum logic [2:0] {
		PH_LEAD     = 3'd0,
		PH_DIGITS   = 3'd1,
		PH_TAIL     = 3'd2,
		PH_LINE_LF  = 3'd3,
		PH_DATA     = 3'd4,
		PH_TRAIL_CR = 3'd5,
		PH_TRAIL_LF = 3'd6
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [SIZE_BITS-1:0]  chunk_size;
		logic [CNT_BITS-1:0]   byte_count;
		logic                  finished;
		logic                  overflow_seen;
	} dchk_state_t;

	typedef struct packed {
		logic                  data_valid;
		logic [BYTE_BITS-1:0]  data_byte;
		logic                  done_res;
		logic                  error;
	} dchk_result_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_digit_t;

	// Classifies an ASCII byte as a hex digit and gives its value.
	function automatic hex_digit_t hex_decode(input logic [BYTE_BITS-1:0] b);
		hex_digit_t h;
		h.is_hex = 1'b0;
		h.value  = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.is_hex = 1'b1;
			h.value  = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.is_hex = 1'b1;
			h.value  = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.is_hex = 1'b1;
			h.value  = 4'(b - 8'h37);
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dchk_step.sv =====
// Next-state and result logic for one body byte of the dechunker.
// Purely combinational; depends on dchk_pkg for the state and result types.
`default_nettype none

module dchk_step (
	input  wire dchk_pkg::dchk_state_t              cur,
	input  wire logic [dchk_pkg::BYTE_BITS-1:0]     byte_in,
	input  wire logic                               chunked_mode,
	input  wire logic [dchk_pkg::LEN_BITS-1:0]      content_length,
	output dchk_pkg::dchk_state_t                   nxt,
	output dchk_pkg::dchk_result_t                  res
);
	import dchk_pkg::*;

	logic [CNT_BITS-1:0]  len_ext;
	logic [SIZE_BITS-1:0] data_count;
	logic [SIZE_BITS-1:0] line_chunk;
	logic [SIZE_BITS-1:0] digit_chunk;
	logic                 digit_ovf;
	phase_t               line_phase;
	logic                 run_line;
	logic                 valid;
	hex_digit_t           hex;

	assign len_ext    = CNT_BITS'(content_length);
	assign data_count = cur.byte_count[SIZE_BITS-1:0] + 1'b1;
	assign hex        = hex_decode(byte_in);

	// A digit that would shift set bits out of the accumulator saturates it.
	always_comb begin
		digit_ovf   = (line_chunk[SIZE_BITS-1 -: 4] != 4'd0);
		digit_chunk = digit_ovf ? {SIZE_BITS{1'b1}}
		                        : {line_chunk[SIZE_BITS-5:0], hex.value};
	end

	always_comb begin
		nxt        = cur;
		valid      = 1'b0;
		line_phase = cur.phase;
		line_chunk = cur.chunk_size;
		run_line   = 1'b0;

		if (!cur.finished) begin
			if (!chunked_mode) begin
				if (cur.byte_count < len_ext) begin
					valid          = 1'b1;
					nxt.byte_count = cur.byte_count + 1'b1;
				end
				if (nxt.byte_count >= len_ext) begin
					nxt.finished = 1'b1;
				end
			end else begin
				case (cur.phase)
					PH_DATA: begin
						valid          = 1'b1;
						nxt.byte_count = CNT_BITS'(data_count);
						if (data_count >= cur.chunk_size) begin
							nxt.phase = PH_TRAIL_CR;
						end
					end
					PH_TRAIL_CR: begin
						if (byte_in == CHAR_CR) begin
							nxt.phase = PH_TRAIL_LF;
						end else begin
							// No CR after the data: this byte opens the next size line.
							line_phase = PH_LEAD;
							line_chunk = '0;
							run_line   = 1'b1;
						end
					end
					PH_TRAIL_LF: begin
						line_phase     = PH_LEAD;
						line_chunk     = '0;
						nxt.phase      = PH_LEAD;
						nxt.chunk_size = '0;
						run_line       = (byte_in != CHAR_LF);
					end
					PH_LEAD, PH_DIGITS, PH_TAIL, PH_LINE_LF: begin
						run_line = 1'b1;
					end
					default: begin
						line_phase = PH_LEAD;
						line_chunk = '0;
						run_line   = 1'b1;
					end
				endcase
			end
		end

		if (run_line) begin
			nxt.phase      = line_phase;
			nxt.chunk_size = line_chunk;
			case (line_phase)
				PH_LEAD: begin
					if (byte_in == CHAR_SP || byte_in == CHAR_TAB) begin
						nxt.phase = PH_LEAD;
					end else if (hex.is_hex) begin
						nxt.chunk_size = digit_chunk;
						nxt.overflow_seen = cur.overflow_seen | digit_ovf;
						nxt.phase = PH_DIGITS;
					end else if (byte_in == CHAR_CR) begin
						nxt.phase = PH_LINE_LF;
					end else begin
						nxt.phase = PH_TAIL;
					end
				end
				PH_DIGITS: begin
					if (hex.is_hex) begin
						nxt.chunk_size = digit_chunk;
						nxt.overflow_seen = cur.overflow_seen | digit_ovf;
					end else if (byte_in == CHAR_CR) begin
						nxt.phase = PH_LINE_LF;
					end else begin
						nxt.phase = PH_TAIL;
					end
				end
				PH_TAIL: begin
					if (byte_in == CHAR_CR) begin
						nxt.phase = PH_LINE_LF;
					end
				end
				default: begin
					// Waiting for the LF that closes the size line.
					if (byte_in == CHAR_LF) begin
						if (line_chunk == '0) begin
							nxt.finished = 1'b1;
						end else begin
							nxt.byte_count = '0;
							nxt.phase      = PH_DATA;
						end
					end else if (byte_in != CHAR_CR) begin
						nxt.phase = PH_TAIL;
					end
				end
			endcase
		end

		res.data_valid = valid;
		res.data_byte  = valid ? byte_in : '0;
		res.done_res   = nxt.finished;
		res.error      = nxt.overflow_seen;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/http_body_dechunker.sv =====
// Top level of the HTTP body dechunker: input stage, decoder state, result
// register and configuration registers. Depends on dchk_pkg and dchk_step.
//
// Usage. Body bytes arrive on the slave stream (s_tvalid, s_tready, s_tdata),
// one byte per transfer. Every accepted byte yields exactly one result transfer
// on the master stream: m_tuser flags a payload byte, m_tdata carries the byte
// (zero when it is not payload), the done flag and the sticky overflow error.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the mode register (index 0) and the content length (index 1); it is always
// ready and should only be used while no bytes are in flight.
//
// Timing. A byte is captured in the input stage and the decoder update runs as
// it moves on into the result register, which drives m_tvalid; a stalled result
// register holds it in the input stage. The state loop closes through state_q
// alone, so the block sustains one byte per clock while m_tready stays high.
//
// Reset clears the decoder to the start of a size line, both configuration
// registers to zero and both pipeline stages to empty. When the receiver holds
// m_tready low the result stays put, the input stage still takes one more byte,
// and s_tready drops once that stage is full as well.
`default_nettype none

module http_body_dechunker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Slave stream. s_tdata: byte_in [7:0].
	input  wire logic                                s_tvalid,
	output      logic                                s_tready,
	input  wire logic [dchk_pkg::BYTE_BITS-1:0]      s_tdata,
	// Master stream. m_tdata: data_byte [7:0], done_res [8], error [9], zeros above.
	// m_tuser: data_valid [0].
	output      logic                                m_tvalid,
	input  wire logic                                m_tready,
	output      logic [dchk_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	output      logic                                m_tuser,
	// Configuration write channel.
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [dchk_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [dchk_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import dchk_pkg::*;

	logic                  valid_s1;
	logic [BYTE_BITS-1:0]  byte_s1;
	logic                  valid_s2;
	dchk_result_t          res_s2;
	dchk_state_t           state_q;
	dchk_state_t           state_nxt;
	dchk_result_t          res_nxt;
	logic                  chunked_mode_q;
	logic [LEN_BITS-1:0]   content_length_q;
	logic                  advance;

	// The input stage moves on when the result register is empty or being drained.
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	dchk_step u_step (
		.cur            (state_q),
		.byte_in        (byte_s1),
		.chunked_mode   (chunked_mode_q),
		.content_length (content_length_q),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	// Decoder state only changes when its byte is committed to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_LEAD;
			state_q.chunk_size    <= '0;
			state_q.byte_count    <= '0;
			state_q.finished      <= 1'b0;
			state_q.overflow_seen <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q   <= 1'b0;
			content_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHUNKED_MODE:   chunked_mode_q   <= cfg_data[0];
				CFG_CONTENT_LENGTH: content_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.data_valid;
	assign m_tdata  = {{(OUT_DATA_BITS - BYTE_BITS - 2){1'b0}},
	                   res_s2.error, res_s2.done_res, res_s2.data_byte};

endmodule

`default_nettype wire

// ===== hw/rtl/dchk_checker.sv =====
// Port-level checker for the HTTP body dechunker and the bind that attaches it.
// Depends on dchk_pkg and the top level http_body_dechunker.
`default_nettype none

module dchk_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic [dchk_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input  wire logic                                m_tuser
);
	import dchk_pkg::*;

	logic done_seen_q;
	logic error_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q  <= 1'b0;
			error_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			done_seen_q  <= done_seen_q | m_tdata[BYTE_BITS];
			error_seen_q <= error_seen_q | m_tdata[BYTE_BITS+1];
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && done_seen_q |-> m_tdata[BYTE_BITS] && !m_tuser)
		else $error("payload or cleared done after the body ended");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && error_seen_q |-> m_tdata[BYTE_BITS+1])
		else $error("overflow error flag dropped");

	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[BYTE_BITS-1:0] == '0)
		else $error("non-payload result carries a nonzero byte");

endmodule

bind http_body_dechunker dchk_checker u_dchk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
